@@ src/utf8_cyrillic_to_cp1251_unit_defines.svh @@
// Assertion macros used by the checker file of the converter.
`ifndef UTF8_CYRILLIC_TO_CP1251_UNIT_DEFINES_SVH
`define UTF8_CYRILLIC_TO_CP1251_UNIT_DEFINES_SVH

// Checked only while the block is out of reset.
`define UCC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("ucc assertion failed");

// Checked at every clock edge, reset included.
`define UCC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ucc assertion failed");

`endif

@@ src/ucc_pkg.sv @@
`default_nettype none

package ucc_pkg;

  // Lead byte held between the two bytes of a pair.
  typedef enum logic [1:0] {
    LEAD_NONE = 2'd0,
    LEAD_C2   = 2'd1,
    LEAD_D0   = 2'd2,
    LEAD_D1   = 2'd3
  } lead_e;

  // One result transaction.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } res_t;

  // Up to two results produced by one input transaction.
  typedef struct packed {
    logic [1:0] num;
    res_t       res0;
    res_t       res1;
  } res_pair_t;

  localparam logic [7:0] ByteC2     = 8'hC2;
  localparam logic [7:0] ByteD0     = 8'hD0;
  localparam logic [7:0] ByteD1     = 8'hD1;
  localparam logic [7:0] ByteLaquo  = 8'hAB;
  localparam logic [7:0] ByteRaquo  = 8'hBB;
  localparam logic [7:0] ByteNbsp   = 8'hA0;
  localparam logic [7:0] OffsetD0   = 8'h30;
  localparam logic [7:0] OffsetD1   = 8'h70;
  localparam logic [7:0] ByteIoUtf  = 8'h81;
  localparam logic [7:0] ByteIoLUtf = 8'h91;
  localparam logic [7:0] ByteIoUp   = 8'hA8;
  localparam logic [7:0] ByteIoLow  = 8'hB8;
  localparam logic [7:0] ByteQuote  = 8'h22;
  localparam logic [7:0] ByteSpace  = 8'h20;
  localparam logic [7:0] CaseDelta  = 8'h20;

  // Result queue geometry.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = 2;
  localparam int unsigned FifoCntW  = 3;

endpackage

`default_nettype wire

@@ src/utf8_cyrillic_to_cp1251_unit.sv @@
// UTF-8 to CP1251 converter for a display font.
// Slave stream: one UTF-8 byte per transaction in s_axis_tdata, s_axis_tlast
// marks the final byte of a string. Master stream: one CP1251 byte per
// transaction; m_axis_tlast is set on the NUL terminator that closes a string.
// A byte may give no result (a held lead, a dropped pair or a byte past the
// length limit), a data byte, or at string end the terminator after any data.
// A result passes the input register, then the decode into the four-entry
// result queue, and waits there behind any results still queued ahead of it.
// Throughput: one input transaction per cycle while the queue holds at most
// two entries; the master side drains one result per cycle, so a run of
// string ends (two results each) is limited by that drain rate.
// upper_mode is written through cfg_we_i / cfg_wdata_i; the user must do so
// only between strings, as the block itself does not enforce it.
// Reset clears the held lead, the string byte count, the queue and upper_mode.
// When the receiver stalls, results collect in the queue and s_axis_tready
// drops once a byte is held and the queue has room for fewer than two results.
`default_nettype none

module utf8_cyrillic_to_cp1251_unit #(
  parameter int unsigned MAX_LEN = 256
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i,     // upper_mode
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,    // [7:0] in_byte
  input  wire logic       s_axis_tlast,    // end_of_string
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,    // [7:0] out_byte
  output logic            m_axis_tlast     // is_last
);

  localparam int unsigned CntW = (MAX_LEN > 2) ? $clog2(MAX_LEN) : 1;

  logic                          upper_q;
  logic                          in_vld_q;
  logic [7:0]                    in_byte_q;
  logic                          in_last_q;
  logic                          adv;
  logic [ucc_pkg::FifoCntW-1:0]  q_count;
  ucc_pkg::res_pair_t            pair;
  ucc_pkg::res_t                 head;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= 1'b0;
    end else if (cfg_we_i) begin
      upper_q <= cfg_wdata_i;
    end
  end

  // The held byte is decoded once the queue has room for two results.
  assign adv           = in_vld_q &&
                         (q_count <= ucc_pkg::FifoCntW'(ucc_pkg::FifoDepth - 2));
  assign s_axis_tready = !in_vld_q || adv;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  ucc_core #(
    .MaxLen (MAX_LEN),
    .CntW   (CntW)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .byte_i  (in_byte_q),
    .last_i  (in_last_q),
    .upper_i (upper_q),
    .pair_o  (pair)
  );

  ucc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (adv),
    .pair_i  (pair),
    .count_o (q_count),
    .valid_o (m_axis_tvalid),
    .head_o  (head),
    .pop_i   (m_axis_tready)
  );

  assign m_axis_tdata = head.data;
  assign m_axis_tlast = head.last;

endmodule

`default_nettype wire

@@ src/ucc_core.sv @@
`default_nettype none

module ucc_core #(
  parameter int unsigned MaxLen = 256,
  parameter int unsigned CntW   = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              adv_i,
  input  wire logic [7:0]        byte_i,
  input  wire logic              last_i,
  input  wire logic              upper_i,
  output ucc_pkg::res_pair_t     pair_o
);

  localparam logic [CntW-1:0] Limit = CntW'(MaxLen - 1);

  ucc_pkg::lead_e  pend_q, pend_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // Upper-case fold of a byte that passes through raw.
  function automatic logic [7:0] fold_raw(input logic [7:0] b, input logic up);
    logic [7:0] r;
    r = b;
    if (up) begin
      if ((b >= 8'h61 && b <= 8'h7A) || b >= 8'hE0) begin
        r = b - ucc_pkg::CaseDelta;
      end else if (b == ucc_pkg::ByteIoLow) begin
        r = ucc_pkg::ByteIoUp;
      end
    end
    return r;
  endfunction

  // Upper-case fold of a mapped Cyrillic letter.
  function automatic logic [7:0] fold_cyr(input logic [7:0] b, input logic up);
    return (up && b >= 8'hE0) ? b - ucc_pkg::CaseDelta : b;
  endfunction

  // Decode of the current byte against the held lead.
  always_comb begin
    logic           hit;
    logic [7:0]     val;
    ucc_pkg::lead_e lead;
    hit    = 1'b0;
    val    = '0;
    lead   = ucc_pkg::LEAD_NONE;
    pend_d = pend_q;
    cnt_d  = cnt_q;
    pair_o.num  = 2'd0;
    pair_o.res0 = '{data: 8'h00, last: 1'b0};
    pair_o.res1 = '{data: 8'h00, last: 1'b1};

    if (pend_q != ucc_pkg::LEAD_NONE) begin
      unique case (pend_q)
        ucc_pkg::LEAD_C2: begin
          if (byte_i == ucc_pkg::ByteLaquo || byte_i == ucc_pkg::ByteRaquo) begin
            hit = 1'b1;
            val = ucc_pkg::ByteQuote;
          end else if (byte_i == ucc_pkg::ByteNbsp) begin
            hit = 1'b1;
            val = ucc_pkg::ByteSpace;
          end
        end
        ucc_pkg::LEAD_D0: begin
          if (byte_i >= 8'h90 && byte_i <= 8'hBF) begin
            hit = 1'b1;
            val = fold_cyr(byte_i + ucc_pkg::OffsetD0, upper_i);
          end else if (byte_i == ucc_pkg::ByteIoUtf) begin
            hit = 1'b1;
            val = ucc_pkg::ByteIoUp;
          end
        end
        ucc_pkg::LEAD_D1: begin
          if (byte_i >= 8'h80 && byte_i <= 8'h8F) begin
            hit = 1'b1;
            val = fold_cyr(byte_i + ucc_pkg::OffsetD1, upper_i);
          end else if (byte_i == ucc_pkg::ByteIoLUtf) begin
            hit = 1'b1;
            val = upper_i ? ucc_pkg::ByteIoUp : ucc_pkg::ByteIoLow;
          end
        end
        default: begin
          hit = 1'b0;
        end
      endcase
      if (hit) begin
        pair_o.num  = 2'd1;
        pair_o.res0 = '{data: val, last: 1'b0};
        cnt_d       = cnt_q + 1'b1;
      end
      pend_d = ucc_pkg::LEAD_NONE;
    end else if (cnt_q < Limit) begin
      if (byte_i == ucc_pkg::ByteC2) begin
        lead = ucc_pkg::LEAD_C2;
      end else if (byte_i == ucc_pkg::ByteD0) begin
        lead = ucc_pkg::LEAD_D0;
      end else if (byte_i == ucc_pkg::ByteD1) begin
        lead = ucc_pkg::LEAD_D1;
      end
      if (lead != ucc_pkg::LEAD_NONE && !last_i) begin
        pend_d = lead;
      end else begin
        // A lead that closes the string goes out unfolded.
        pair_o.num  = 2'd1;
        pair_o.res0 = '{data: (lead != ucc_pkg::LEAD_NONE) ? byte_i
                                                            : fold_raw(byte_i, upper_i),
                        last: 1'b0};
        cnt_d       = cnt_q + 1'b1;
      end
    end

    // The terminator follows whatever data the byte produced.
    if (last_i) begin
      if (pair_o.num == 2'd0) begin
        pair_o.res0 = '{data: 8'h00, last: 1'b1};
      end
      pair_o.num = pair_o.num + 2'd1;
      pend_d     = ucc_pkg::LEAD_NONE;
      cnt_d      = '0;
    end
  end

  // String state advances only when the decoded byte is committed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= ucc_pkg::LEAD_NONE;
      cnt_q  <= '0;
    end else if (adv_i) begin
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ src/ucc_fifo.sv @@
`default_nettype none

module ucc_fifo (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             push_i,
  input  wire ucc_pkg::res_pair_t               pair_i,
  output logic [ucc_pkg::FifoCntW-1:0]          count_o,
  output logic                                  valid_o,
  output ucc_pkg::res_t                         head_o,
  input  wire logic                             pop_i
);

  ucc_pkg::res_t                  mem_q [ucc_pkg::FifoDepth];
  logic [ucc_pkg::FifoPtrW-1:0]   wr_q, rd_q;
  logic [ucc_pkg::FifoCntW-1:0]   cnt_q, cnt_d;
  logic [1:0]                     n_push;
  logic                           do_pop;

  assign n_push  = push_i ? pair_i.num : 2'd0;
  assign valid_o = (cnt_q != '0);
  assign do_pop  = pop_i && valid_o;
  assign head_o  = mem_q[rd_q];
  assign count_o = cnt_q;
  assign cnt_d   = cnt_q + ucc_pkg::FifoCntW'(n_push) - ucc_pkg::FifoCntW'(do_pop);

  // Result storage, up to two entries written per cycle.
  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wr_q] <= pair_i.res0;
    end
    if (n_push == 2'd2) begin
      mem_q[wr_q + 1'b1] <= pair_i.res1;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + ucc_pkg::FifoPtrW'(n_push);
      rd_q  <= rd_q + ucc_pkg::FifoPtrW'(do_pop);
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ src/ucc_checker.sv @@
`default_nettype none
`include "utf8_cyrillic_to_cp1251_unit_defines.svh"

module ucc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tlast
);

  // No result is offered in the cycle after reset is seen.
  `UCC_ASSERT_ALWAYS(a_idle_in_reset, clk_i, !rst_ni |=> !m_axis_tvalid)

  // The input side only stalls while results are queued.
  `UCC_ASSERT(a_stall_has_output, clk_i, rst_ni, !s_axis_tready |-> m_axis_tvalid)

  // A terminator always carries the NUL byte.
  `UCC_ASSERT(a_term_is_nul, clk_i, rst_ni,
              (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata == 8'h00))

  // A stalled result transaction holds.
  `UCC_ASSERT(a_out_hold, clk_i, rst_ni,
              (m_axis_tvalid && !m_axis_tready) |=>
              (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))

endmodule

bind utf8_cyrillic_to_cp1251_unit ucc_checker u_ucc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
